// ===== hdl/ifr_pkg.sv =====
// ============================================================================
// ifr_pkg: shared definitions for the integer factor resampler
// Holds the sizing constants, the mode and state types, the control and
// status structs between controller and datapath, and the factor clamp.
// ============================================================================
package ifr_pkg;

    localparam int SAMPLE_WIDTH  = 24;
    localparam int MAX_FACTOR    = 64;

    // Stream payload width, sample padded up to whole bytes.
    localparam int TDATA_W       = ((SAMPLE_WIDTH + 7) / 8) * 8;

    // Configuration port.
    localparam int MODE_W        = 2;
    localparam int FACTOR_REG_W  = 7;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = FACTOR_REG_W;

    // Effective factor and decimation phase widths.
    localparam int FW            = $clog2(MAX_FACTOR + 1);
    localparam int PHASE_W       = $clog2(MAX_FACTOR);

    // Biased dividend for the linear slope divider, processed DIV_BITS a cycle.
    localparam int DW            = SAMPLE_WIDTH + FW;
    localparam int DIV_BITS      = 4;
    localparam int DIV_CYC       = (DW + DIV_BITS - 1) / DIV_BITS;
    localparam int DWP           = DIV_CYC * DIV_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_CYC);

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 1'b1;

    localparam logic [FACTOR_REG_W-1:0] FACTOR_RESET = 7'd4;

    typedef enum logic [MODE_W-1:0] {
        MODE_DECIMATE   = 2'd0,
        MODE_ZERO_STUFF = 2'd1,
        MODE_HOLD       = 2'd2,
        MODE_LINEAR     = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  phase_zero;
        logic  div_done;
        logic  emit_last;
        logic  out_free;
    } t_status;

    // Factors below two act as two, factors above the maximum act as the maximum.
    function automatic logic [FW-1:0] eff_factor(input logic [FACTOR_REG_W-1:0] raw);
        logic [FW-1:0] res;
        if (int'(raw) < 2) begin
            res = FW'(2);
        end else if (int'(raw) > MAX_FACTOR) begin
            res = FW'(MAX_FACTOR);
        end else begin
            res = FW'(raw);
        end
        return res;
    endfunction

endpackage

// ===== hdl/ifr_ctrl.sv =====
// ============================================================================
// ifr_ctrl: controller of the integer factor resampler
// Sequences each item through an optional slope division and the emission
// of its results, if it has any, and drives the input handshake.
// ============================================================================
module ifr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  ifr_pkg::t_status  i_status,
    output ifr_pkg::t_cmd     o_cmd
);

    ifr_pkg::t_state r_state;
    ifr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ifr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ifr_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    case (i_status.mode)
                        ifr_pkg::MODE_DECIMATE: begin
                            n_state = i_status.phase_zero ? ifr_pkg::ST_EMIT
                                                          : ifr_pkg::ST_IDLE;
                        end
                        ifr_pkg::MODE_LINEAR: begin
                            n_state = ifr_pkg::ST_DIVIDE;
                        end
                        default: begin
                            n_state = ifr_pkg::ST_EMIT;
                        end
                    endcase
                end
            end
            ifr_pkg::ST_DIVIDE: begin
                if (i_status.div_done) begin
                    n_state = ifr_pkg::ST_EMIT;
                end
            end
            ifr_pkg::ST_EMIT: begin
                if (i_status.out_free && i_status.emit_last) begin
                    n_state = ifr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ifr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_tready     = (r_state == ifr_pkg::ST_IDLE);
        o_cmd.load     = (r_state == ifr_pkg::ST_IDLE) && i_s_tvalid;
        o_cmd.div_step = (r_state == ifr_pkg::ST_DIVIDE);
        o_cmd.emit     = (r_state == ifr_pkg::ST_EMIT) && i_status.out_free;
    end

`ifndef SYNTHESIS
    // The divider never stops short of its full cycle count.
    a_div_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ifr_pkg::ST_DIVIDE && !i_status.div_done)
            |=> (r_state == ifr_pkg::ST_DIVIDE))
        else $error("divide state left before the quotient was complete");

    // After the final result of an item the controller is ready for the next.
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_status.emit_last) |=> (r_state == ifr_pkg::ST_IDLE))
        else $error("controller did not return to idle after the last result");

    // Emission overlaps neither division nor loading.
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.emit && o_cmd.div_step) && !(o_cmd.load && o_cmd.emit))
        else $error("conflicting datapath commands");
`endif

endmodule

// ===== hdl/ifr_dp.sv =====
// ============================================================================
// ifr_dp: datapath of the integer factor resampler
// Configuration registers, decimation phase, previous sample, a radix-16
// restoring divider for the linear slope, the interpolation accumulator and
// the output register.
// ============================================================================
module ifr_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ifr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ifr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [ifr_pkg::SAMPLE_WIDTH-1:0]  i_sample,
    input  ifr_pkg::t_cmd                     i_cmd,
    output ifr_pkg::t_status                  o_status,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [ifr_pkg::SAMPLE_WIDTH-1:0]  o_m_sample,
    output logic                              o_m_last
);

    localparam int SW = ifr_pkg::SAMPLE_WIDTH;
    localparam int FW = ifr_pkg::FW;

    // Configuration.
    ifr_pkg::t_mode                       r_mode_cfg;
    logic [ifr_pkg::FACTOR_REG_W-1:0]     r_fac_cfg;

    // Persistent state.
    logic [ifr_pkg::PHASE_W-1:0]          r_phase;
    logic [SW-1:0]                        r_prev;

    // Per item.
    ifr_pkg::t_mode                       r_mode;
    logic [FW-1:0]                        r_fac;
    logic [SW-1:0]                        r_sample;
    logic signed [SW:0]                   r_acc;
    logic [FW-1:0]                        r_frac;
    logic [FW-1:0]                        r_j;
    logic                                 r_single;

    // Divider.
    logic [ifr_pkg::DWP-1:0]              r_num;
    logic [ifr_pkg::DWP-1:0]              r_quo;
    logic [FW-1:0]                        r_rem;
    logic [ifr_pkg::DIV_CNT_W-1:0]        r_div_cnt;

    // Output register.
    logic                                 r_out_valid;
    logic [SW-1:0]                        r_out_data;
    logic                                 r_out_last;

    logic [FW-1:0]                        f_eff;
    logic signed [SW:0]                   diff;
    logic [ifr_pkg::DWP-1:0]              dividend;
    logic [ifr_pkg::DWP-1:0]              n_num;
    logic [ifr_pkg::DWP-1:0]              n_quo;
    logic [FW-1:0]                        n_rem;
    logic [FW:0]                          frac_sum;
    logic                                 carry;
    logic [FW-1:0]                        n_frac;
    logic signed [SW:0]                   qd_ext;
    logic signed [SW:0]                   n_acc;
    logic [SW-1:0]                        emit_val;
    logic                                 out_free;
    logic                                 emit_last;

    assign f_eff = ifr_pkg::eff_factor(r_fac_cfg);

    // Bias the slope by factor << SW so the dividend is always positive; the
    // low SW quotient bits are then the floored signed quotient.
    always_comb begin
        diff     = $signed({i_sample[SW-1], i_sample}) - $signed({r_prev[SW-1], r_prev});
        dividend = ifr_pkg::DWP'({f_eff, {SW{1'b0}}}) + ifr_pkg::DWP'(diff);
    end

    always_comb begin
        logic [FW:0]             rem;
        logic [ifr_pkg::DWP-1:0] num;
        logic [ifr_pkg::DWP-1:0] quo;
        logic                    qb;
        rem = {1'b0, r_rem};
        num = r_num;
        quo = r_quo;
        for (int k = 0; k < ifr_pkg::DIV_BITS; k++) begin
            rem = {rem[FW-1:0], num[ifr_pkg::DWP-1]};
            num = {num[ifr_pkg::DWP-2:0], 1'b0};
            qb  = (rem >= {1'b0, r_fac});
            if (qb) begin
                rem = rem - {1'b0, r_fac};
            end
            quo = {quo[ifr_pkg::DWP-2:0], qb};
        end
        n_rem = rem[FW-1:0];
        n_num = num;
        n_quo = quo;
    end

    // One interpolation step: add quotient, carry from the fractional part.
    always_comb begin
        frac_sum = {1'b0, r_frac} + {1'b0, r_rem};
        carry    = (frac_sum >= {1'b0, r_fac});
        n_frac   = carry ? FW'(frac_sum - {1'b0, r_fac}) : frac_sum[FW-1:0];
        qd_ext   = (SW + 1)'($signed(r_quo[SW-1:0]));
        n_acc    = r_acc + qd_ext + $signed({{SW{1'b0}}, carry});
    end

    always_comb begin
        case (r_mode)
            ifr_pkg::MODE_ZERO_STUFF: emit_val = (r_j == '0) ? r_sample : '0;
            ifr_pkg::MODE_LINEAR:     emit_val = n_acc[SW-1:0];
            default:                  emit_val = r_sample;
        endcase
    end

    assign out_free  = !r_out_valid || i_m_tready;
    assign emit_last = r_single || (r_j == r_fac - FW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_cfg <= ifr_pkg::MODE_ZERO_STUFF;
            r_fac_cfg  <= ifr_pkg::FACTOR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ifr_pkg::CFG_MODE:   r_mode_cfg <= ifr_pkg::t_mode'(i_cfg_data[ifr_pkg::MODE_W-1:0]);
                ifr_pkg::CFG_FACTOR: r_fac_cfg  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_prev  <= '0;
        end else if (i_cmd.load) begin
            if (r_mode_cfg == ifr_pkg::MODE_DECIMATE) begin
                if (FW'(r_phase) >= f_eff - FW'(1)) begin
                    r_phase <= '0;
                end else begin
                    r_phase <= r_phase + 1'b1;
                end
            end
            if (r_mode_cfg == ifr_pkg::MODE_LINEAR) begin
                r_prev <= i_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= r_mode_cfg;
            r_fac     <= f_eff;
            r_sample  <= i_sample;
            r_acc     <= $signed({r_prev[SW-1], r_prev});
            r_frac    <= '0;
            r_j       <= '0;
            r_single  <= (r_mode_cfg == ifr_pkg::MODE_DECIMATE);
            r_num     <= dividend;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_num     <= n_num;
            r_quo     <= n_quo;
            r_rem     <= n_rem;
            r_div_cnt <= r_div_cnt + 1'b1;
        end else if (i_cmd.emit) begin
            r_acc  <= n_acc;
            r_frac <= n_frac;
            r_j    <= r_j + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= emit_val;
            r_out_last <= emit_last;
        end
    end

    always_comb begin
        o_status.mode       = r_mode_cfg;
        o_status.phase_zero = (r_phase == '0);
        o_status.div_done   = (r_div_cnt == ifr_pkg::DIV_CNT_W'(ifr_pkg::DIV_CYC - 1));
        o_status.emit_last  = emit_last;
        o_status.out_free   = out_free;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_sample = r_out_data;
    assign o_m_last   = r_out_last;

endmodule

// ===== hdl/integer_factor_resampler.sv =====
// An item with results takes the controller to its emit state, in linear mode by
// way of the slope divider, and each result leaves through the output register.
// Items are taken one at a time: zero-stuff, hold and linear give factor results
// per item, decimate one for a kept sample and none for a dropped one.
// Results go one per cycle unless output stalls; divider takes 4 bits a cycle.
// Reset (synchronous, active low): mode zero-stuff, factor 4, phase and previous 0.
// ============================================================================
// integer_factor_resampler: sample-rate converter by an integer factor
// Decimates, zero-stuffs, holds or linearly interpolates a stream of signed
// fixed-point samples under a small register interface.
// ============================================================================
module integer_factor_resampler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration writes: index 0 is mode, index 1 is factor.
    input  logic                               i_cfg_we,
    input  logic [ifr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ifr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ifr_pkg::TDATA_W-1:0]        s_axis_tdata,  // sample_in
    // Output stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ifr_pkg::TDATA_W-1:0]        m_axis_tdata,  // sample_out
    output logic                               m_axis_tlast   // last_of_run
);

    // The controller and datapath talk only through these two structs.
    ifr_pkg::t_cmd    cmd;
    ifr_pkg::t_status status;

    logic [ifr_pkg::SAMPLE_WIDTH-1:0] sample_out;

    // The controller accepts a new item only from idle; the output register in
    // the datapath lets the last result of one item wait while the next item
    // is taken in.
    ifr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath holds the configuration, the decimation phase, the previous
    // sample for interpolation, the slope divider and the output register.
    // Linear interpolation avoids a per-result divide: the slope is divided
    // once per item into a quotient and remainder, and each result then adds
    // the quotient plus a carry from a running remainder.
    ifr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (s_axis_tdata[ifr_pkg::SAMPLE_WIDTH-1:0]),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_sample (sample_out),
        .o_m_last   (m_axis_tlast)
    );

    // Pad bits above the sample are always zero.
    assign m_axis_tdata = ifr_pkg::TDATA_W'(sample_out);

endmodule

// ===== tb/tb_integer_factor_resampler.sv =====
// ============================================================================
// tb_integer_factor_resampler: self-checking bench for the resampler
// Drives sample items through all four modes under varying factors, predicts
// every result in the bench, and checks each output item in order while the
// input and output sides idle and stall at random.
// ============================================================================
module tb_integer_factor_resampler;

    localparam int LIMIT_CYCLES = 1_000_000;
    // Cycles to let the block settle once no result is outstanding. This covers
    // a dropped decimate item and the slope divider of linear mode.
    localparam int SETTLE_CYCLES = 2 * ifr_pkg::DIV_CYC + 4;
    localparam int HOLD_OFF_CYCLES = 400;

    localparam logic [ifr_pkg::SAMPLE_WIDTH-1:0] SAMPLE_MAX =
        {1'b0, {(ifr_pkg::SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [ifr_pkg::SAMPLE_WIDTH-1:0] SAMPLE_MIN =
        {1'b1, {(ifr_pkg::SAMPLE_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [ifr_pkg::SAMPLE_WIDTH-1:0] sample;
        logic                             last;
    } t_resample;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_cfg_we = 1'b0;
    logic [ifr_pkg::CFG_IDX_W-1:0]        i_cfg_idx = '0;
    logic [ifr_pkg::CFG_DATA_W-1:0]       i_cfg_data = '0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    logic [ifr_pkg::TDATA_W-1:0]          s_axis_tdata = '0;   // sample_in
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    logic [ifr_pkg::TDATA_W-1:0]          m_axis_tdata;        // sample_out
    logic                                 m_axis_tlast;        // last_of_run

    // Bench copy of the configuration and of the block's state.
    ifr_pkg::t_mode                       cfg_mode = ifr_pkg::MODE_ZERO_STUFF;
    logic [ifr_pkg::FACTOR_REG_W-1:0]     cfg_factor = ifr_pkg::FACTOR_RESET;
    int                                   decim_phase = 0;
    longint                               prev_sample = 0;

    t_resample                            pending_outputs[$];

    int gap_pct = 0;        // chance in percent that the sender idles a cycle
    int stall_pct = 0;      // chance in percent that the receiver stalls a cycle
    int hold_left = 0;      // receiver hold-off still to run, in cycles
    int items_sent = 0;
    int results_checked = 0;
    int config_writes = 0;
    int error_count = 0;
    int cycle_count = 0;

    integer_factor_resampler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // The run is cut off if it goes on far longer than any correct run could.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, pending_outputs.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Works out the results of one accepted sample and queues them in order.
    // Decimate mode keeps the first sample of each group; the phase wraps once
    // it reaches factor-1, which also covers a phase left high by a factor
    // change. The other modes give factor results, the last one flagged.
    function automatic void predict_resample(input logic [ifr_pkg::SAMPLE_WIDTH-1:0] raw);
        logic signed [ifr_pkg::SAMPLE_WIDTH-1:0] cur_s;
        longint    cur;
        longint    num;
        longint    quo;
        longint    val;
        int        ratio;
        t_resample res;
        cur_s = raw;
        cur = cur_s;
        ratio = int'(cfg_factor);
        if (ratio < 2) begin
            ratio = 2;
        end else if (ratio > ifr_pkg::MAX_FACTOR) begin
            ratio = ifr_pkg::MAX_FACTOR;
        end
        if (cfg_mode == ifr_pkg::MODE_DECIMATE) begin
            if (decim_phase == 0) begin
                res.sample = raw;
                res.last = 1'b1;
                pending_outputs.push_back(res);
            end
            decim_phase = (decim_phase >= ratio - 1) ? 0 : decim_phase + 1;
        end else begin
            for (int j = 0; j < ratio; j++) begin
                case (cfg_mode)
                    ifr_pkg::MODE_ZERO_STUFF: begin
                        val = (j == 0) ? cur : 0;
                    end
                    ifr_pkg::MODE_HOLD: begin
                        val = cur;
                    end
                    default: begin
                        // Exact slope step, rounded toward minus infinity.
                        num = (cur - prev_sample) * longint'(j + 1);
                        quo = num / ratio;
                        if ((num % ratio) != 0 && num < 0) begin
                            quo--;
                        end
                        val = prev_sample + quo;
                    end
                endcase
                res.sample = val[ifr_pkg::SAMPLE_WIDTH-1:0];
                res.last = (j == ratio - 1);
                pending_outputs.push_back(res);
            end
            if (cfg_mode == ifr_pkg::MODE_LINEAR) begin
                prev_sample = cur;
            end
        end
    endfunction

    // Prediction and checking share one process so that an item accepted and
    // a result taken at the same edge are handled in a fixed order.
    always @(posedge i_clk) begin : check_results
        t_resample want;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_resample(s_axis_tdata[ifr_pkg::SAMPLE_WIDTH-1:0]);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_checked++;
            if (pending_outputs.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, got sample %h last %b",
                         $time, m_axis_tdata[ifr_pkg::SAMPLE_WIDTH-1:0],
                         m_axis_tlast);
            end else begin
                want = pending_outputs.pop_front();
                if (m_axis_tdata[ifr_pkg::SAMPLE_WIDTH-1:0] !== want.sample) begin
                    error_count++;
                    $display("%0t: sample_out mismatch, expected %h, got %h",
                             $time, want.sample,
                             m_axis_tdata[ifr_pkg::SAMPLE_WIDTH-1:0]);
                end
                if (m_axis_tlast !== want.last) begin
                    error_count++;
                    $display("%0t: last_of_run mismatch, expected %b, got %b",
                             $time, want.last, m_axis_tlast);
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when a test asks for one.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offers one sample, idling first at random, and returns once it is taken.
    task automatic send_sample(input logic [ifr_pkg::SAMPLE_WIDTH-1:0] smp);
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ifr_pkg::TDATA_W'(smp);
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        items_sent++;
    endtask

    // Lowers valid, waits for every outstanding result, then lets the block settle.
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_outputs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes mode and then factor; only called while the block is idle.
    task automatic set_config(input ifr_pkg::t_mode md,
                              input logic [ifr_pkg::FACTOR_REG_W-1:0] fac);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= ifr_pkg::CFG_MODE;
        i_cfg_data <= ifr_pkg::CFG_DATA_W'(md);
        @(posedge i_clk);
        i_cfg_idx <= ifr_pkg::CFG_FACTOR;
        i_cfg_data <= fac;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_mode = md;
        cfg_factor = fac;
        config_writes += 2;
    endtask

    function automatic logic [ifr_pkg::SAMPLE_WIDTH-1:0] pick_sample();
        logic [ifr_pkg::SAMPLE_WIDTH-1:0] smp;
        case ($urandom_range(9))
            0: smp = SAMPLE_MAX;
            1: smp = SAMPLE_MIN;
            2: smp = ifr_pkg::SAMPLE_WIDTH'($urandom_range(15))
                     - ifr_pkg::SAMPLE_WIDTH'(8);
            default: smp = ifr_pkg::SAMPLE_WIDTH'($urandom);
        endcase
        return smp;
    endfunction

    // Mostly small factors to keep the run short, now and then the largest
    // one and raw values that the block must clamp.
    function automatic logic [ifr_pkg::FACTOR_REG_W-1:0] pick_factor();
        logic [ifr_pkg::FACTOR_REG_W-1:0] fac;
        case ($urandom_range(19))
            0: fac = ifr_pkg::FACTOR_REG_W'(ifr_pkg::MAX_FACTOR);
            1: fac = ifr_pkg::FACTOR_REG_W'($urandom_range(1));
            2: fac = ifr_pkg::FACTOR_REG_W'($urandom_range(127, ifr_pkg::MAX_FACTOR + 1));
            3: fac = ifr_pkg::FACTOR_REG_W'($urandom_range(ifr_pkg::MAX_FACTOR - 1, 17));
            default: fac = ifr_pkg::FACTOR_REG_W'($urandom_range(16, 2));
        endcase
        return fac;
    endfunction

    // Straight after reset the block must zero-stuff by four.
    task automatic test_reset_defaults();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample('1);
        wait_drain();
    endtask

    // Factors below two act as two, factors above the maximum as the maximum.
    task automatic test_factor_clamp();
        set_config(ifr_pkg::MODE_HOLD, 7'd0);
        send_sample(24'h123456);
        wait_drain();
        set_config(ifr_pkg::MODE_ZERO_STUFF, 7'd1);
        send_sample(24'hABCDEF);
        wait_drain();
        set_config(ifr_pkg::MODE_HOLD, ifr_pkg::FACTOR_REG_W'(ifr_pkg::MAX_FACTOR + 1));
        send_sample(24'h5A5A5A);
        wait_drain();
        set_config(ifr_pkg::MODE_ZERO_STUFF, 7'd127);
        send_sample(24'hA5A5A5);
        wait_drain();
    endtask

    // Dropped samples, and a phase left beyond the new factor that must wrap.
    task automatic test_decimate_phase();
        set_config(ifr_pkg::MODE_DECIMATE, 7'd8);
        for (int k = 0; k < 5; k++) begin
            send_sample(ifr_pkg::SAMPLE_WIDTH'(k * 1000 + 17));
        end
        wait_drain();
        set_config(ifr_pkg::MODE_DECIMATE, 7'd3);
        send_sample(24'h111111);
        send_sample(24'h222222);
        send_sample(24'h333333);
        wait_drain();
    endtask

    // Full-scale jumps at the largest factor, then negative slopes where the
    // rounding toward minus infinity matters.
    task automatic test_linear_interp();
        set_config(ifr_pkg::MODE_LINEAR, ifr_pkg::FACTOR_REG_W'(ifr_pkg::MAX_FACTOR));
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        wait_drain();
        set_config(ifr_pkg::MODE_LINEAR, 7'd3);
        send_sample(-ifr_pkg::SAMPLE_WIDTH'(5));
        send_sample(ifr_pkg::SAMPLE_WIDTH'(7));
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        wait_drain();
    endtask

    // The previous sample survives a detour through another mode.
    task automatic test_mode_state();
        set_config(ifr_pkg::MODE_HOLD, 7'd2);
        send_sample(24'h000100);
        wait_drain();
        set_config(ifr_pkg::MODE_LINEAR, 7'd5);
        send_sample(-ifr_pkg::SAMPLE_WIDTH'(3));
        wait_drain();
    endtask

    // The receiver holds off long enough for the block to stall its input
    // while the sender keeps offering items; then the sender waits it out.
    task automatic test_backpressure();
        set_config(ifr_pkg::MODE_ZERO_STUFF, 7'd16);
        gap_pct = 0;
        stall_pct = 0;
        hold_left = HOLD_OFF_CYCLES;
        for (int k = 0; k < 30; k++) begin
            send_sample(pick_sample());
        end
        wait_drain();
    endtask

    // Runs of random items, each under a random setting, with the block
    // drained before the next setting is written.
    task automatic test_random_runs(input int sender_gap, input int receiver_stall,
                                    input int run_items);
        int done;
        int run_len;
        done = 0;
        gap_pct = sender_gap;
        stall_pct = receiver_stall;
        while (done < run_items) begin
            set_config(ifr_pkg::t_mode'($urandom_range(3)), pick_factor());
            run_len = $urandom_range(24, 8);
            for (int k = 0; k < run_len; k++) begin
                send_sample(pick_sample());
            end
            done += run_len;
            wait_drain();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_factor_clamp();
        test_decimate_phase();
        test_linear_interp();
        test_mode_state();
        test_backpressure();
        test_random_runs(21, 61, 80);
        test_random_runs(61, 21, 80);
        test_random_runs(0, 0, 80);

        if (pending_outputs.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected results never arrived",
                     $time, pending_outputs.size());
        end
        $display("Sent %0d sample items and checked %0d results in %0d cycles,",
                 items_sent, results_checked, cycle_count);
        $display("covering all four modes, clamped factors and %0d register writes.",
                 config_writes);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches found", error_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ifr_pkg.sv
hdl/ifr_ctrl.sv
hdl/ifr_dp.sv
hdl/integer_factor_resampler.sv
tb/tb_integer_factor_resampler.sv
